[rtl/core/afc_pkg.sv]
package afc_pkg;

  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_HEADER = 3'd1;
  localparam logic [2:0] KIND_PIXEL  = 3'd2;
  localparam logic [2:0] KIND_END    = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  localparam logic [1:0] DISP_NONE = 2'd0;
  localparam logic [1:0] DISP_BG   = 2'd1;
  localparam logic [1:0] DISP_PREV = 2'd2;
  localparam logic [1:0] DISP_BAD  = 2'd3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HIDDEN = 2'd2;

  localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;
  localparam logic [7:0]  ALPHA_FULL   = 8'hFF;
  localparam logic [7:0]  ALPHA_NONE   = 8'h00;
  localparam logic [7:0]  CH_MAX       = 8'd255;

  localparam int DIV_LANES = 3;
  localparam int DIV_NW    = 24;
  localparam int DIV_DW    = 16;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [8:0] size_w;
    logic [8:0] size_h;
    logic [1:0] dispose_op;
    logic       blend_op;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
    logic [7:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
  } out_item_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_CLEAR, S_BACKUP, S_RESTORE, S_BG,
    S_BRD, S_BM2, S_BM3, S_DIV, S_WB, S_RDWAIT, S_RESP
  } state_e;

  typedef struct packed {
    logic latch;
    logic reg_clear;
    logic hdr_apply;
    logic end_apply;
    logic cur_adv;
    logic sweep_init;
    logic clear_step;
    logic copy_fwd;
    logic copy_back;
    logic bg_step;
    logic pix_src;
    logic res_drop;
    logic res_ok;
    logic res_read;
    logic rd_pix;
    logic rd_xy;
    logic blend_m1;
    logic blend_fast;
    logic blend_m2;
    logic div_start;
    logic div_take;
    logic wb;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       hdr_copy;
    logic       excess;
    logic       pix_out;
    logic       pix_blend;
    logic       rd_in;
    logic       end_restore;
    logic       end_bg;
    logic       fast;
    logic       sweep_done;
    logic       copy_done;
    logic       bg_done;
    logic       div_done;
    logic       out_free;
  } dp_status_t;

endpackage

[rtl/core/afc_ram.sv]
module afc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/afc_div.sv]
module afc_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [afc_pkg::DIV_LANES-1:0][afc_pkg::DIV_NW-1:0] num_i,
  input  logic [afc_pkg::DIV_LANES-1:0][afc_pkg::DIV_DW-1:0] den_i,
  output logic done_o,
  output logic [afc_pkg::DIV_LANES-1:0][afc_pkg::DIV_NW-1:0] quo_o
);

  localparam int CW = $clog2(afc_pkg::DIV_NW + 1);

  logic [afc_pkg::DIV_LANES-1:0][afc_pkg::DIV_DW-1:0] rem_q, rem_d, den_q;
  logic [afc_pkg::DIV_LANES-1:0][afc_pkg::DIV_NW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  // one restoring step per lane: shift in the next numerator bit, subtract if it fits
  always_comb begin
    logic [afc_pkg::DIV_DW:0] sh;
    for (int l = 0; l < afc_pkg::DIV_LANES; l++) begin
      sh = {rem_q[l], quo_q[l][afc_pkg::DIV_NW-1]};
      if (sh >= {1'b0, den_q[l]}) begin
        rem_d[l] = afc_pkg::DIV_DW'(sh - {1'b0, den_q[l]});
        quo_d[l] = {quo_q[l][afc_pkg::DIV_NW-2:0], 1'b1};
      end else begin
        rem_d[l] = sh[afc_pkg::DIV_DW-1:0];
        quo_d[l] = {quo_q[l][afc_pkg::DIV_NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(afc_pkg::DIV_NW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/core/afc_datapath.sv]
module afc_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  afc_pkg::in_item_t     in_item_i,
  input  logic [8:0]            cfg_width_i,
  input  logic [8:0]            cfg_height_i,
  input  logic                  cfg_first_hidden_i,
  input  afc_pkg::ctrl_cmd_t    cmd_i,
  output afc_pkg::dp_status_t   status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output afc_pkg::out_item_t    out_item_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

  afc_pkg::in_item_t item_q;
  logic [15:0] fc_q;
  logic [7:0]  rx_q, ry_q;
  logic [8:0]  rw_q, rh_q, col_q, row_q, bc_q, br_q;
  logic [1:0]  disp_q;
  logic        blend_q;
  logic [AW:0]   sw_q;
  logic [AW-1:0] wa_q, addr_q;
  logic          wv_q;
  logic [1:0]  res_st_q;
  logic [31:0] res_px_q, dst_q;
  logic [15:0] u_q, v_q;
  logic [2:0][23:0] su_q, dv_q;
  afc_pkg::out_item_t out_q;
  logic        out_valid_q;

  function automatic logic in_cv(logic [9:0] x, logic [9:0] y);
    return ({3'b0, x} < MaxW) && (x < {1'b0, cfg_width_i}) &&
           ({3'b0, y} < MaxH) && (y < {1'b0, cfg_height_i});
  endfunction

  function automatic logic [AW-1:0] addr_of(logic [9:0] x, logic [9:0] y);
    logic [25:0] t;
    t = 26'(y) * 26'(MAX_WIDTH) + 26'(x);
    return t[AW-1:0];
  endfunction

  logic        hidden, first_shown, hdr_copy, sweep_done, bg_done, bg_in;
  logic [1:0]  hdr_disp;
  logic        hdr_blend;
  logic [9:0]  pix_x, pix_y, bg_x, bg_y, rd_x, rd_y;
  logic [9:0]  col_n, bc_n;
  logic [31:0] src, fast_px;
  logic [7:0]  sa, da;
  logic        fast;

  assign hidden = cfg_first_hidden_i && (fc_q == 16'd0);
  assign first_shown = ((fc_q == 16'd0) && !cfg_first_hidden_i) ||
                       ((fc_q == 16'd1) && cfg_first_hidden_i);

  always_comb begin
    hdr_disp = item_q.dispose_op;
    if (hdr_disp == afc_pkg::DISP_BAD) begin
      hdr_disp = afc_pkg::DISP_NONE;
    end
    if (first_shown && hdr_disp == afc_pkg::DISP_PREV) begin
      hdr_disp = afc_pkg::DISP_BG;
    end
  end
  assign hdr_blend = first_shown ? 1'b0 : item_q.blend_op;
  assign hdr_copy  = !hidden && (hdr_disp == afc_pkg::DISP_PREV);

  assign pix_x = {2'b0, rx_q} + {1'b0, col_q};
  assign pix_y = {2'b0, ry_q} + {1'b0, row_q};
  assign bg_x  = {2'b0, rx_q} + {1'b0, bc_q};
  assign bg_y  = {2'b0, ry_q} + {1'b0, br_q};
  assign rd_x  = {2'b0, item_q.pos_x};
  assign rd_y  = {2'b0, item_q.pos_y};
  assign col_n = {1'b0, col_q} + 10'd1;
  assign bc_n  = {1'b0, bc_q} + 10'd1;
  assign bg_in = in_cv(bg_x, bg_y);

  assign sweep_done = (sw_q == (AW+1)'(DEPTH));
  assign bg_done    = (rw_q == 9'd0) || (br_q >= rh_q);

  // memories
  logic          cv_we, cv_re, bk_we, bk_re;
  logic [AW-1:0] cv_waddr, cv_raddr;
  logic [31:0]   cv_wdata, cv_rdata, bk_rdata;

  always_comb begin
    cv_we    = 1'b0;
    cv_waddr = wa_q;
    cv_wdata = afc_pkg::OPAQUE_BLACK;
    if (cmd_i.clear_step && !sweep_done) begin
      cv_we    = 1'b1;
      cv_waddr = sw_q[AW-1:0];
    end else if (cmd_i.copy_back && wv_q) begin
      cv_we    = 1'b1;
      cv_wdata = bk_rdata;
    end else if (cmd_i.bg_step && !bg_done && bg_in) begin
      cv_we    = 1'b1;
      cv_waddr = addr_of(bg_x, bg_y);
    end else if (cmd_i.wb) begin
      cv_we    = 1'b1;
      cv_waddr = addr_q;
      cv_wdata = res_px_q;
    end
    cv_re    = 1'b0;
    cv_raddr = sw_q[AW-1:0];
    if (cmd_i.copy_fwd && !sweep_done) begin
      cv_re = 1'b1;
    end else if (cmd_i.rd_pix) begin
      cv_re    = 1'b1;
      cv_raddr = addr_of(pix_x, pix_y);
    end else if (cmd_i.rd_xy) begin
      cv_re    = 1'b1;
      cv_raddr = addr_of(rd_x, rd_y);
    end
  end

  assign bk_we = cmd_i.copy_fwd && wv_q;
  assign bk_re = cmd_i.copy_back && !sweep_done;

  afc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_canvas (
    .clk_i   (clk_i),
    .we_i    (cv_we),
    .waddr_i (cv_waddr),
    .wdata_i (cv_wdata),
    .re_i    (cv_re),
    .raddr_i (cv_raddr),
    .rdata_o (cv_rdata)
  );

  afc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_backup (
    .clk_i   (clk_i),
    .we_i    (bk_we),
    .waddr_i (wa_q),
    .wdata_i (cv_rdata),
    .re_i    (bk_re),
    .raddr_i (sw_q[AW-1:0]),
    .rdata_o (bk_rdata)
  );

  // blend
  assign src = {item_q.in_alpha, item_q.in_red, item_q.in_green, item_q.in_blue};
  assign sa  = item_q.in_alpha;
  assign da  = cv_rdata[31:24];
  assign fast = (sa == afc_pkg::ALPHA_FULL) || (sa == afc_pkg::ALPHA_NONE) ||
                (da == afc_pkg::ALPHA_NONE);
  assign fast_px = (sa == afc_pkg::ALPHA_NONE) ? cv_rdata : src;

  logic [15:0] al, al_sum;
  logic [7:0]  al_div;
  logic [afc_pkg::DIV_LANES-1:0][afc_pkg::DIV_NW-1:0] div_num, div_quo;
  logic [afc_pkg::DIV_LANES-1:0][afc_pkg::DIV_DW-1:0] div_den;
  logic div_done;

  assign al = u_q + v_q;
  // divide by 255 as (x + 1 + x/256) / 256, exact over the whole alpha range
  assign al_sum = al + 16'd1 + {8'b0, al[15:8]};
  assign al_div = al_sum[15:8];

  always_comb begin
    for (int c = 0; c < afc_pkg::DIV_LANES; c++) begin
      div_num[c] = su_q[c] + dv_q[c];
      div_den[c] = al;
    end
  end

  afc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_item_i;
    end
    if (cmd_i.blend_m1) begin
      u_q   <= 16'({8'b0, sa} * {8'b0, afc_pkg::CH_MAX});
      v_q   <= 16'({8'b0, afc_pkg::CH_MAX - sa} * {8'b0, da});
      dst_q <= cv_rdata;
    end
    if (cmd_i.blend_m2) begin
      for (int c = 0; c < 3; c++) begin
        su_q[c] <= {16'b0, src[8*c +: 8]} * {8'b0, u_q};
        dv_q[c] <= {16'b0, dst_q[8*c +: 8]} * {8'b0, v_q};
      end
    end
    if (cmd_i.rd_pix || cmd_i.pix_src) begin
      addr_q <= addr_of(pix_x, pix_y);
    end
    if (cmd_i.res_drop) begin
      res_st_q <= afc_pkg::ST_DROP;
      res_px_q <= '0;
    end else if (cmd_i.res_ok) begin
      res_st_q <= afc_pkg::ST_OK;
      res_px_q <= '0;
    end else if (cmd_i.pix_src) begin
      res_st_q <= afc_pkg::ST_OK;
      res_px_q <= src;
    end else if (cmd_i.res_read) begin
      res_st_q <= afc_pkg::ST_READ;
      res_px_q <= cv_rdata;
    end else if (cmd_i.blend_fast) begin
      res_st_q <= afc_pkg::ST_OK;
      res_px_q <= fast_px;
    end else if (cmd_i.div_take) begin
      res_st_q <= afc_pkg::ST_OK;
      res_px_q <= {al_div, div_quo[2][7:0], div_quo[1][7:0], div_quo[0][7:0]};
    end
    if (cmd_i.out_load) begin
      out_q <= '{status: res_st_q, out_blue: res_px_q[7:0], out_green: res_px_q[15:8],
                 out_red: res_px_q[23:16], out_alpha: res_px_q[31:24]};
    end
  end

  // frame state, cursor, sweep counters and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= '0; rx_q <= '0; ry_q <= '0; rw_q <= '0; rh_q <= '0;
      disp_q <= afc_pkg::DISP_NONE; blend_q <= 1'b0;
      col_q <= '0; row_q <= '0;
      sw_q <= '0; wa_q <= '0; wv_q <= 1'b0; bc_q <= '0; br_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.reg_clear) begin
        fc_q <= '0; rx_q <= '0; ry_q <= '0; rw_q <= '0; rh_q <= '0;
        disp_q <= afc_pkg::DISP_NONE; blend_q <= 1'b0;
        col_q <= '0; row_q <= '0;
      end
      if (cmd_i.hdr_apply) begin
        rx_q <= item_q.pos_x;
        ry_q <= item_q.pos_y;
        rw_q <= item_q.size_w;
        rh_q <= item_q.size_h;
        disp_q <= hdr_disp;
        blend_q <= hdr_blend;
        col_q <= '0;
        row_q <= '0;
      end
      if (cmd_i.cur_adv) begin
        if (col_n >= {1'b0, rw_q}) begin
          col_q <= '0;
          row_q <= row_q + 9'd1;
        end else begin
          col_q <= col_n[8:0];
        end
      end
      if (cmd_i.end_apply) begin
        col_q <= '0;
        row_q <= rh_q;
        if (fc_q != 16'hFFFF) begin
          fc_q <= fc_q + 16'd1;
        end
      end
      if (cmd_i.sweep_init) begin
        sw_q <= '0;
        wv_q <= 1'b0;
        bc_q <= '0;
        br_q <= '0;
      end else begin
        // copy sweeps write one entry behind the read
        if (cmd_i.copy_fwd || cmd_i.copy_back) begin
          wv_q <= !sweep_done;
          wa_q <= sw_q[AW-1:0];
        end
        if ((cmd_i.clear_step || cmd_i.copy_fwd || cmd_i.copy_back) && !sweep_done) begin
          sw_q <= sw_q + 1'b1;
        end
        if (cmd_i.bg_step && !bg_done) begin
          if (bc_n >= {1'b0, rw_q}) begin
            bc_q <= '0;
            br_q <= br_q + 9'd1;
          end else begin
            bc_q <= bc_n[8:0];
          end
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o = '{
    kind:        item_q.kind,
    hdr_copy:    hdr_copy,
    excess:      (rw_q == 9'd0) || (row_q >= rh_q),
    pix_out:     hidden || !in_cv(pix_x, pix_y),
    pix_blend:   blend_q,
    rd_in:       in_cv(rd_x, rd_y),
    end_restore: !hidden && (disp_q == afc_pkg::DISP_PREV),
    end_bg:      !hidden && (disp_q == afc_pkg::DISP_BG),
    fast:        fast,
    sweep_done:  sweep_done,
    copy_done:   sweep_done && !wv_q,
    bg_done:     bg_done,
    div_done:    div_done,
    out_free:    !out_valid_q || out_ready_i
  };

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[rtl/core/afc_ctrl.sv]
module afc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  afc_pkg::dp_status_t status_i,
  output afc_pkg::ctrl_cmd_t  cmd_o
);

  afc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afc_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      afc_pkg::S_INIT: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.sweep_done) state_d = afc_pkg::S_IDLE;
      end
      afc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = afc_pkg::S_DECODE;
        end
      end
      afc_pkg::S_DECODE: begin
        unique case (status_i.kind)
          afc_pkg::KIND_START: begin
            cmd_o.reg_clear  = 1'b1;
            cmd_o.sweep_init = 1'b1;
            cmd_o.res_ok     = 1'b1;
            state_d = afc_pkg::S_CLEAR;
          end
          afc_pkg::KIND_HEADER: begin
            cmd_o.hdr_apply = 1'b1;
            cmd_o.res_ok    = 1'b1;
            if (status_i.hdr_copy) begin
              cmd_o.sweep_init = 1'b1;
              state_d = afc_pkg::S_BACKUP;
            end else begin
              state_d = afc_pkg::S_RESP;
            end
          end
          afc_pkg::KIND_PIXEL: begin
            if (status_i.excess) begin
              cmd_o.res_drop = 1'b1;
              state_d = afc_pkg::S_RESP;
            end else begin
              cmd_o.cur_adv = 1'b1;
              if (status_i.pix_out) begin
                cmd_o.res_drop = 1'b1;
                state_d = afc_pkg::S_RESP;
              end else if (status_i.pix_blend) begin
                cmd_o.rd_pix = 1'b1;
                state_d = afc_pkg::S_BRD;
              end else begin
                cmd_o.pix_src = 1'b1;
                state_d = afc_pkg::S_WB;
              end
            end
          end
          afc_pkg::KIND_END: begin
            cmd_o.end_apply = 1'b1;
            cmd_o.res_ok    = 1'b1;
            if (status_i.end_restore) begin
              cmd_o.sweep_init = 1'b1;
              state_d = afc_pkg::S_RESTORE;
            end else if (status_i.end_bg) begin
              cmd_o.sweep_init = 1'b1;
              state_d = afc_pkg::S_BG;
            end else begin
              state_d = afc_pkg::S_RESP;
            end
          end
          afc_pkg::KIND_READ: begin
            if (status_i.rd_in) begin
              cmd_o.rd_xy = 1'b1;
              state_d = afc_pkg::S_RDWAIT;
            end else begin
              cmd_o.res_drop = 1'b1;
              state_d = afc_pkg::S_RESP;
            end
          end
          default: begin
            cmd_o.res_ok = 1'b1;
            state_d = afc_pkg::S_RESP;
          end
        endcase
      end
      afc_pkg::S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.sweep_done) state_d = afc_pkg::S_RESP;
      end
      afc_pkg::S_BACKUP: begin
        cmd_o.copy_fwd = 1'b1;
        if (status_i.copy_done) state_d = afc_pkg::S_RESP;
      end
      afc_pkg::S_RESTORE: begin
        cmd_o.copy_back = 1'b1;
        if (status_i.copy_done) state_d = afc_pkg::S_RESP;
      end
      afc_pkg::S_BG: begin
        if (status_i.bg_done) begin
          state_d = afc_pkg::S_RESP;
        end else begin
          cmd_o.bg_step = 1'b1;
        end
      end
      afc_pkg::S_BRD: begin
        if (status_i.fast) begin
          cmd_o.blend_fast = 1'b1;
          state_d = afc_pkg::S_WB;
        end else begin
          cmd_o.blend_m1 = 1'b1;
          state_d = afc_pkg::S_BM2;
        end
      end
      afc_pkg::S_BM2: begin
        cmd_o.blend_m2 = 1'b1;
        state_d = afc_pkg::S_BM3;
      end
      afc_pkg::S_BM3: begin
        cmd_o.div_start = 1'b1;
        state_d = afc_pkg::S_DIV;
      end
      afc_pkg::S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = afc_pkg::S_WB;
        end
      end
      afc_pkg::S_WB: begin
        cmd_o.wb = 1'b1;
        state_d = afc_pkg::S_RESP;
      end
      afc_pkg::S_RDWAIT: begin
        cmd_o.res_read = 1'b1;
        state_d = afc_pkg::S_RESP;
      end
      afc_pkg::S_RESP: begin
        // hold until the output register can take the beat
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = afc_pkg::S_IDLE;
        end
      end
      default: state_d = afc_pkg::S_IDLE;
    endcase
  end

endmodule

[rtl/core/apng_frame_compositor.sv]
// One item at a time. Source-copy pixel: write-back; read: canvas read; over-blend pixel:
// canvas read, then the copy shortcuts or a 24-step divider over three colours, then
// write-back. Start image and dispose sweeps run one canvas entry a cycle: all
// MAX_WIDTH*MAX_HEIGHT entries for clear, backup and restore; region width*height for
// background. Reset (rst_ni low, asynchronous) clears control state, then the canvas
// is painted opaque black, entry by entry, before the first input beat is taken.
module apng_frame_compositor #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  afc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output afc_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [8:0] cw_q, ch_q;
  logic       fh_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q <= 9'd256;
      ch_q <= 9'd256;
      fh_q <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        afc_pkg::REG_WIDTH:  cw_q <= pwdata[8:0];
        afc_pkg::REG_HEIGHT: ch_q <= pwdata[8:0];
        afc_pkg::REG_HIDDEN: fh_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      afc_pkg::REG_WIDTH:  prdata = {23'b0, cw_q};
      afc_pkg::REG_HEIGHT: prdata = {23'b0, ch_q};
      afc_pkg::REG_HIDDEN: prdata = {31'b0, fh_q};
      default:             prdata = '0;
    endcase
  end

  afc_pkg::ctrl_cmd_t  cmd;
  afc_pkg::dp_status_t status;

  afc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  afc_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_item_i          (in_item_i),
    .cfg_width_i        (cw_q),
    .cfg_height_i       (ch_q),
    .cfg_first_hidden_i (fh_q),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .out_item_o         (out_item_o)
  );

endmodule

[tb/tb.sv]
module tb;
  import afc_pkg::*;

  class canvas_scoreboard;
    out_item_t   expected_q[$];
    int unsigned mismatches;
    logic [8:0]  canvas_w;
    logic [8:0]  canvas_h;
    bit          hidden_first;
    logic [31:0] canvas_mem[65536];
    logic [31:0] backup_mem[65536];
    int          frames;
    int          reg_x, reg_y, reg_w, reg_h;
    logic [1:0]  disp;
    bit          blend;
    int          col, row;

    function new();
      canvas_w = 9'd256;
      canvas_h = 9'd256;
      hidden_first = 1'b0;
      foreach (backup_mem[i]) backup_mem[i] = '0;
      clear_all();
    endfunction

    function void clear_all();
      foreach (canvas_mem[i]) canvas_mem[i] = OPAQUE_BLACK;
      frames = 0;
      reg_x = 0; reg_y = 0; reg_w = 0; reg_h = 0;
      disp = DISP_NONE;
      blend = 1'b0;
      col = 0; row = 0;
    endfunction

    function bit on_canvas(int x, int y);
      return x < canvas_w && x < 256 && y < canvas_h && y < 256;
    endfunction

    function bit frame_hidden();
      return hidden_first && frames == 0;
    endfunction

    function logic [31:0] over(logic [31:0] src, logic [31:0] dst);
      int a, da, u, v, al;
      logic [31:0] res;
      a = src[31:24];
      da = dst[31:24];
      if (a == ALPHA_FULL) return src;
      if (a == ALPHA_NONE) return dst;
      if (da == ALPHA_NONE) return src;
      u = a * CH_MAX;
      v = (CH_MAX - a) * da;
      al = u + v;
      res = '0;
      res[31:24] = al / CH_MAX;
      for (int sh = 0; sh < 24; sh += 8)
        res[sh+:8] = (int'(src[sh+:8]) * u + int'(dst[sh+:8]) * v) / al;
      return res;
    endfunction

    function void note_input(in_item_t it);
      out_item_t   exp;
      bit          first_shown;
      int          x, y;
      logic [31:0] px;
      exp = '0;
      exp.status = ST_OK;
      case (it.kind)
        KIND_START: clear_all();
        KIND_HEADER: begin
          first_shown = (frames == 0 && !hidden_first) || (frames == 1 && hidden_first);
          reg_x = it.pos_x;
          reg_y = it.pos_y;
          reg_w = it.size_w;
          reg_h = it.size_h;
          disp = (it.dispose_op == DISP_BAD) ? DISP_NONE : it.dispose_op;
          blend = it.blend_op;
          if (first_shown) begin
            blend = 1'b0;
            if (disp == DISP_PREV) disp = DISP_BG;
          end
          col = 0;
          row = 0;
          if (!frame_hidden() && disp == DISP_PREV) backup_mem = canvas_mem;
        end
        KIND_PIXEL: begin
          if (reg_w == 0 || row >= reg_h) begin
            exp.status = ST_DROP;
          end else begin
            x = reg_x + col;
            y = reg_y + row;
            col++;
            if (col >= reg_w) begin
              col = 0;
              row++;
            end
            if (frame_hidden() || !on_canvas(x, y)) begin
              exp.status = ST_DROP;
            end else begin
              px = {it.in_alpha, it.in_red, it.in_green, it.in_blue};
              if (blend) px = over(px, canvas_mem[y*256 + x]);
              canvas_mem[y*256 + x] = px;
              {exp.out_alpha, exp.out_red, exp.out_green, exp.out_blue} = px;
            end
          end
        end
        KIND_END: begin
          if (!frame_hidden()) begin
            if (disp == DISP_PREV) begin
              canvas_mem = backup_mem;
            end else if (disp == DISP_BG) begin
              for (int r = 0; r < reg_h; r++)
                for (int c = 0; c < reg_w; c++)
                  if (on_canvas(reg_x + c, reg_y + r))
                    canvas_mem[(reg_y + r)*256 + reg_x + c] = OPAQUE_BLACK;
            end
          end
          col = 0;
          row = reg_h;
          if (frames < 65535) frames++;
        end
        KIND_READ: begin
          if (on_canvas(it.pos_x, it.pos_y)) begin
            exp.status = ST_READ;
            {exp.out_alpha, exp.out_red, exp.out_green, exp.out_blue} =
              canvas_mem[int'(it.pos_y)*256 + it.pos_x];
          end else begin
            exp.status = ST_DROP;
          end
        end
        default: ;
      endcase
      expected_q.push_back(exp);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        mismatches++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        mismatches++;
      end
      if (got.out_blue !== exp.out_blue) begin
        $error("out_blue: expected %0d, got %0d", exp.out_blue, got.out_blue);
        mismatches++;
      end
      if (got.out_green !== exp.out_green) begin
        $error("out_green: expected %0d, got %0d", exp.out_green, got.out_green);
        mismatches++;
      end
      if (got.out_red !== exp.out_red) begin
        $error("out_red: expected %0d, got %0d", exp.out_red, got.out_red);
        mismatches++;
      end
      if (got.out_alpha !== exp.out_alpha) begin
        $error("out_alpha: expected %0d, got %0d", exp.out_alpha, got.out_alpha);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  canvas_scoreboard sb;
  int  burst_left;
  int  items_sent;
  int  prev_left;
  bit  hold_go;

  apng_frame_compositor i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: switch stall pattern every so often; hold off on request.
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);

  task automatic send(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
    items_sent++;
  endtask

  // Hold the sender until every expected beat is back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_WIDTH:  sb.canvas_w = val[8:0];
      REG_HEIGHT: sb.canvas_h = val[8:0];
      REG_HIDDEN: sb.hidden_first = val[0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic in_item_t mk_kind(logic [2:0] k);
    in_item_t it;
    it = '0;
    it.kind = k;
    return it;
  endfunction

  function automatic in_item_t mk_header(int x, int y, int w, int h, logic [1:0] d, bit b);
    in_item_t it;
    it = mk_kind(KIND_HEADER);
    it.pos_x = x;
    it.pos_y = y;
    it.size_w = w;
    it.size_h = h;
    it.dispose_op = d;
    it.blend_op = b;
    return it;
  endfunction

  function automatic in_item_t mk_pixel(logic [31:0] argb);
    in_item_t it;
    it = mk_kind(KIND_PIXEL);
    {it.in_alpha, it.in_red, it.in_green, it.in_blue} = argb;
    return it;
  endfunction

  function automatic in_item_t mk_read(int x, int y);
    in_item_t it;
    it = mk_kind(KIND_READ);
    it.pos_x = x;
    it.pos_y = y;
    return it;
  endfunction

  function automatic in_item_t rnd_pixel();
    in_item_t it;
    it = {$urandom, $urandom, $urandom};
    it.kind = KIND_PIXEL;
    case ($urandom_range(0, 3))
      0: it.in_alpha = ALPHA_NONE;
      1: it.in_alpha = ALPHA_FULL;
      default: ;
    endcase
    return it;
  endfunction

  task automatic random_frame(int cw, int ch);
    int x, y, w, h, npix;
    logic [1:0] d;
    x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, cw - 1);
    y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, ch - 1);
    case ($urandom_range(0, 39))
      0: begin w = 0; h = $urandom_range(0, 3); end
      1: begin w = $urandom_range(256, 511); h = 1; end
      2: begin w = 1; h = $urandom_range(256, 511); end
      3: begin w = $urandom_range(1, 4); h = 0; end
      default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 6); end
    endcase
    d = $urandom_range(0, 3);
    if (d == DISP_PREV) begin
      if (prev_left > 0 && $urandom_range(0, 7) == 0) prev_left--;
      else d = $urandom_range(0, 1) ? DISP_BG : DISP_BAD;
    end
    send(mk_header(x, y, w, h, d, $urandom_range(0, 1)));
    npix = (w * h > 48) ? 48 : w * h;
    case ($urandom_range(0, 9))
      0: npix = npix + $urandom_range(1, 3);
      1: npix = $urandom_range(0, npix);
      default: ;
    endcase
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 9) == 0)
        send(mk_read($urandom_range(0, cw), $urandom_range(0, ch)));
      send(rnd_pixel());
    end
    send(mk_kind(KIND_END));
    if ($urandom_range(0, 1)) send(mk_read(x, y));
  endtask

  task automatic noise_item(int cw, int ch);
    in_item_t it;
    it = {$urandom, $urandom, $urandom};
    case ($urandom_range(0, 4))
      0: it.kind = KIND_PIXEL;
      1: begin
        it.kind = KIND_READ;
        if ($urandom_range(0, 1)) begin
          it.pos_x = $urandom_range(0, cw - 1);
          it.pos_y = $urandom_range(0, ch - 1);
        end
      end
      // frame end with no header only where it restores nothing
      2: it.kind = (sb.disp == DISP_PREV) ? KIND_READ : KIND_END;
      default: it.kind = $urandom_range(5, 7);
    endcase
    send(it);
  endtask

  task automatic run_phase(int cw, int ch, bit hid, int n, bit long_hold);
    int stop_at;
    drain();
    reg_write(REG_WIDTH, cw);
    reg_write(REG_HEIGHT, ch);
    reg_write(REG_HIDDEN, hid);
    repeat (2) @(posedge clk_i);
    send(mk_kind(KIND_START));
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if (long_hold && items_sent > stop_at - n / 2) begin
        long_hold = 1'b0;
        hold_go = 1'b1;
      end
      if ($urandom_range(0, 6) == 0) noise_item(cw, ch);
      else random_frame(cw, ch);
    end
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    items_sent = 0;
    prev_left = 3;
    hold_go = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first shown frame: over becomes source, previous becomes background
    send(mk_read(0, 0));
    send(mk_header(0, 0, 2, 1, DISP_PREV, 1'b1));
    send(mk_pixel(32'h0011_2233));
    send(mk_pixel(32'hFF44_5566));
    send(mk_read(0, 0));
    send(mk_kind(KIND_END));
    send(mk_read(1, 0));
    // leave a transparent pixel for the next frame to land on
    send(mk_header(10, 10, 2, 2, DISP_NONE, 1'b0));
    send(mk_pixel(32'h0001_0203));
    send(mk_pixel(32'h80C0_4020));
    send(mk_pixel(32'hFFFF_FFFF));
    send(mk_kind(KIND_END));
    send(mk_header(10, 10, 2, 2, DISP_PREV, 1'b1));
    send(mk_pixel(32'h4010_2030));
    send(mk_pixel(32'h00AA_BBCC));
    send(mk_pixel(32'h8020_40FF));
    send(mk_pixel(32'h8080_8080));
    send(mk_pixel(32'hFF00_0000));
    send(mk_kind(KIND_END));
    send(mk_read(10, 10));
    send(mk_header(254, 254, 4, 2, DISP_BAD, 1'b1));
    send(mk_pixel(32'h7F7F_7F7F));
    send(mk_pixel(32'hC012_3456));
    send(mk_pixel(32'hFF65_4321));
    send(mk_kind(3'd7));
    send(mk_kind(KIND_END));
    send(mk_kind(KIND_END));
    send(mk_read(255, 254));

    run_phase(256, 256, 1'b0, 240, 1'b1);
    run_phase(1, 1, 1'b1, 160, 1'b0);
    run_phase(13, 200, 1'b1, 240, 1'b0);
    run_phase(256, 1, 1'b0, 240, 1'b0);

    drain();
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/afc_pkg.sv
rtl/core/afc_ram.sv
rtl/core/afc_div.sv
rtl/core/afc_datapath.sv
rtl/core/afc_ctrl.sv
rtl/core/apng_frame_compositor.sv
tb/tb.sv
